FILE: hdl/mds_pkg.sv
package mds_pkg;

   localparam int MaxUsers    = 4;
   localparam int MaxCodeLen  = 512;
   localparam int SymbolBits  = 16;

   localparam int UserIdxW    = (MaxUsers > 1) ? $clog2(MaxUsers) : 1;
   localparam int UsersW      = $clog2(MaxUsers + 1);
   localparam int AddrW       = $clog2(MaxCodeLen);
   localparam int LenW        = AddrW + 1;
   localparam int ChipW       = 19;
   localparam int SumW        = SymbolBits + UserIdxW + 2;
   localparam int ScaleW      = 16;
   localparam int ScaleShift  = 15;
   localparam int ProdW       = SumW + ScaleW + 1;

   localparam int SpreadLog2W   = 4;
   localparam int SpreadLog2Min = 5;
   localparam int SpreadLog2Max = 9;

   localparam int CsrIdxW     = 3;
   localparam int CsrDataW    = LenW;

   localparam int LoadAddrLsb = UserIdxW;
   localparam int LoadChipBit = UserIdxW + AddrW;
   localparam int SymLsb      = UserIdxW + AddrW + 1;
   localparam int ReqDataW    = ((SymLsb + 2 * MaxUsers * SymbolBits + 7) / 8) * 8;
   localparam int RspDataW    = ((2 * ChipW + 7) / 8) * 8;

   typedef enum logic {
      OpLoad = 1'b0,
      OpChip = 1'b1
   } op_type;

   typedef enum logic [CsrIdxW-1:0] {
      RegSpreadLog2  = 3'd0,
      RegActiveUsers = 3'd1,
      RegScaleEnable = 3'd2,
      RegCodeLen0    = 3'd3,
      RegCodeLen1    = 3'd4,
      RegCodeLen2    = 3'd5,
      RegCodeLen3    = 3'd6
   } reg_idx_type;

   typedef logic signed [SymbolBits-1:0] sym_type;
   typedef logic signed [ChipW-1:0]      chip_type;

   typedef struct packed {
      sym_type re;
      sym_type im;
   } cplx_type;

   typedef struct packed {
      logic [MaxUsers-1:0] active;
      logic [MaxUsers-1:0] code_bit;
      logic [UsersW-1:0]   users_n;
      logic                scale_en;
   } comb_ctrl_type;

   function automatic logic [ScaleW-1:0] inv_sqrt_q15(input logic [UsersW-1:0] n);
      logic [ScaleW-1:0] k;
      begin
         unique case (n)
            3'd2:    k = 16'd23170;
            3'd3:    k = 16'd18919;
            3'd4:    k = 16'd16384;
            default: k = 16'd32768;
         endcase
         return k;
      end
   endfunction

endpackage

FILE: hdl/mds_combiner.sv
module mds_combiner (
   input  mds_pkg::comb_ctrl_type                  ctrl,
   input  mds_pkg::cplx_type [mds_pkg::MaxUsers-1:0] sym,
   output mds_pkg::chip_type                       chip_re,
   output mds_pkg::chip_type                       chip_im
);

   logic signed [mds_pkg::SumW-1:0]  sum_re;
   logic signed [mds_pkg::SumW-1:0]  sum_im;
   logic signed [mds_pkg::SumW-1:0]  term_re;
   logic signed [mds_pkg::SumW-1:0]  term_im;
   logic signed [mds_pkg::ProdW-1:0] k_s;
   logic signed [mds_pkg::ProdW-1:0] prod_re;
   logic signed [mds_pkg::ProdW-1:0] prod_im;
   logic signed [mds_pkg::ProdW-1:0] shr_re;
   logic signed [mds_pkg::ProdW-1:0] shr_im;

   always_comb begin
      sum_re = '0;
      sum_im = '0;
      for (int u = 0; u < mds_pkg::MaxUsers; u++) begin
         term_re = mds_pkg::SumW'(sym[u].re);
         term_im = mds_pkg::SumW'(sym[u].im);
         if (ctrl.active[u]) begin
            if (ctrl.code_bit[u]) begin
               sum_re = sum_re + term_re;
               sum_im = sum_im + term_im;
            end else begin
               sum_re = sum_re - term_re;
               sum_im = sum_im - term_im;
            end
         end
      end
   end

   assign k_s     = mds_pkg::ProdW'(signed'({1'b0, mds_pkg::inv_sqrt_q15(ctrl.users_n)}));
   assign prod_re = mds_pkg::ProdW'(sum_re) * k_s;
   assign prod_im = mds_pkg::ProdW'(sum_im) * k_s;
   assign shr_re  = prod_re >>> mds_pkg::ScaleShift;
   assign shr_im  = prod_im >>> mds_pkg::ScaleShift;

   assign chip_re = ctrl.scale_en ? shr_re[mds_pkg::ChipW-1:0] : sum_re[mds_pkg::ChipW-1:0];
   assign chip_im = ctrl.scale_en ? shr_im[mds_pkg::ChipW-1:0] : sum_im[mds_pkg::ChipW-1:0];

endmodule

FILE: hdl/multiuser_dsss_spreader.sv
// Channel  Direction  Handshake              Payload
// req      in         req_tvalid/req_tready  tuser op, tdata load and symbol fields
// rsp      out        rsp_tvalid/rsp_tready  tdata chip_re/chip_im, tlast symbol_end
// csr      in         csr_valid/csr_ready    csr_index, csr_data
//
// One item per cycle while the result path is not stalled; a chip item's result passes
// through the code store read register, then the result register.
// Reset is synchronous: config returns to defaults and phases clear; the code
// store is not cleared and reads as unknown until loaded.
// A stalled result holds in the result register; one more item waits in the
// read stage before req_tready drops.
// csr_ready is always high.
module multiuser_dsss_spreader (
   input  logic                            clock,
   input  logic                            reset,

   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [mds_pkg::ReqDataW-1:0]    req_tdata,  // load_user, load_addr, load_chip, user0_re, user0_im, ... user3_im
   input  logic                            req_tuser,  // op

   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [mds_pkg::RspDataW-1:0]    rsp_tdata,  // chip_re, chip_im
   output logic                            rsp_tlast,

   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [mds_pkg::CsrIdxW-1:0]     csr_index,
   input  logic [mds_pkg::CsrDataW-1:0]    csr_data
);

   localparam int MaxUsers = mds_pkg::MaxUsers;
   localparam int AddrW    = mds_pkg::AddrW;
   localparam int LenW     = mds_pkg::LenW;
   localparam int UsersW   = mds_pkg::UsersW;

   logic                               req_accept;
   logic                               csr_accept;
   logic                               load_accept;
   logic                               chip_accept;
   logic                               restart;
   logic                               s2_ready;

   logic [mds_pkg::UserIdxW-1:0]       load_user;
   logic [AddrW-1:0]                   load_addr;
   logic                               load_chip;
   mds_pkg::cplx_type [MaxUsers-1:0]   req_sym;

   logic [mds_pkg::SpreadLog2W-1:0]    spread_log2_ff;
   logic [2:0]                         active_users_ff;
   logic                               scale_enable_ff;
   logic [MaxUsers-1:0][LenW-1:0]      code_len_ff;

   logic [mds_pkg::SpreadLog2W-1:0]    log2_c;
   logic [LenW-1:0]                    sf_w;
   logic [AddrW-1:0]                   sf_m1;
   logic [UsersW-1:0]                  users_n;
   logic [MaxUsers-1:0]                active;

   logic [MaxUsers-1:0][AddrW-1:0]     code_phase_ff;
   logic [MaxUsers-1:0][AddrW-1:0]     code_phase_in;
   logic [AddrW-1:0]                   chip_in_symbol_ff;
   logic [AddrW-1:0]                   chip_in_symbol_in;

   logic                               s1_valid_ff;
   logic                               s1_valid_in;
   logic                               s1_last_ff;
   mds_pkg::cplx_type [MaxUsers-1:0]   s1_sym_ff;
   mds_pkg::comb_ctrl_type             s1_ctrl_ff;
   logic [MaxUsers-1:0]                code_bit_ff;
   mds_pkg::comb_ctrl_type             comb_ctrl;

   mds_pkg::chip_type                  chip_re;
   mds_pkg::chip_type                  chip_im;
   logic                               rsp_valid_ff;
   logic                               rsp_valid_in;
   mds_pkg::chip_type                  rsp_re_ff;
   mds_pkg::chip_type                  rsp_im_ff;
   logic                               rsp_last_ff;

   assign csr_ready   = 1'b1;
   assign csr_accept  = csr_valid & csr_ready;
   assign req_accept  = req_tvalid & req_tready;
   assign load_accept = req_accept & (req_tuser == mds_pkg::OpLoad);
   assign chip_accept = req_accept & (req_tuser == mds_pkg::OpChip);

   assign load_user = req_tdata[0 +: mds_pkg::UserIdxW];
   assign load_addr = req_tdata[mds_pkg::LoadAddrLsb +: AddrW];
   assign load_chip = req_tdata[mds_pkg::LoadChipBit];

   for (genvar u = 0; u < MaxUsers; u++) begin : g_unpack
      assign req_sym[u].re = req_tdata[mds_pkg::SymLsb + 2*u*mds_pkg::SymbolBits
                                       +: mds_pkg::SymbolBits];
      assign req_sym[u].im = req_tdata[mds_pkg::SymLsb + (2*u+1)*mds_pkg::SymbolBits
                                       +: mds_pkg::SymbolBits];
   end

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         spread_log2_ff  <= mds_pkg::SpreadLog2W'(mds_pkg::SpreadLog2Min);
         active_users_ff <= 3'(MaxUsers);
         scale_enable_ff <= 1'b1;
      end else if (csr_accept) begin
         unique case (csr_index)
            mds_pkg::RegSpreadLog2:  spread_log2_ff  <= csr_data[mds_pkg::SpreadLog2W-1:0];
            mds_pkg::RegActiveUsers: active_users_ff <= csr_data[2:0];
            mds_pkg::RegScaleEnable: scale_enable_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   for (genvar u = 0; u < MaxUsers; u++) begin : g_len
      always_ff @(posedge clock) begin
         if (reset) begin
            code_len_ff[u] <= LenW'(32);
         end else if (csr_accept
                      && csr_index == mds_pkg::CsrIdxW'(int'(mds_pkg::RegCodeLen0) + u)) begin
            code_len_ff[u] <= csr_data[LenW-1:0];
         end
      end
   end

   assign restart = load_accept
                  | (csr_accept & ((csr_index == mds_pkg::RegSpreadLog2)
                                   | ((csr_index >= mds_pkg::RegCodeLen0)
                                      & (csr_index <= mds_pkg::RegCodeLen3))));

   always_comb begin
      if (spread_log2_ff < mds_pkg::SpreadLog2W'(mds_pkg::SpreadLog2Min)) begin
         log2_c = mds_pkg::SpreadLog2W'(mds_pkg::SpreadLog2Min);
      end else if (spread_log2_ff > mds_pkg::SpreadLog2W'(mds_pkg::SpreadLog2Max)) begin
         log2_c = mds_pkg::SpreadLog2W'(mds_pkg::SpreadLog2Max);
      end else begin
         log2_c = spread_log2_ff;
      end
      sf_w  = LenW'(1) << log2_c;
      sf_m1 = AddrW'(sf_w - LenW'(1));

      if (active_users_ff == 3'd0) begin
         users_n = UsersW'(1);
      end else if (active_users_ff > 3'(MaxUsers)) begin
         users_n = UsersW'(MaxUsers);
      end else begin
         users_n = UsersW'(active_users_ff);
      end
   end

   // code store, phase tracking
   for (genvar u = 0; u < MaxUsers; u++) begin : g_user
      logic            code_mem [mds_pkg::MaxCodeLen];
      logic [LenW-1:0] len_c;
      logic [LenW-1:0] ph_inc;

      assign active[u] = (UsersW'(u) < users_n);

      always_comb begin
         if (code_len_ff[u] == '0) begin
            len_c = LenW'(1);
         end else if (code_len_ff[u] > LenW'(mds_pkg::MaxCodeLen)) begin
            len_c = LenW'(mds_pkg::MaxCodeLen);
         end else begin
            len_c = code_len_ff[u];
         end
         ph_inc = {1'b0, code_phase_ff[u]} + LenW'(1);

         priority if (restart) begin
            code_phase_in[u] = '0;
         end else if (chip_accept && active[u]) begin
            code_phase_in[u] = (ph_inc >= len_c) ? '0 : ph_inc[AddrW-1:0];
         end else begin
            code_phase_in[u] = code_phase_ff[u];
         end
      end

      always_ff @(posedge clock) begin
         if (load_accept && load_user == mds_pkg::UserIdxW'(u)) begin
            code_mem[load_addr] <= load_chip;
         end
         if (chip_accept) begin
            code_bit_ff[u] <= code_mem[code_phase_ff[u]];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            code_phase_ff[u] <= '0;
         end else begin
            code_phase_ff[u] <= code_phase_in[u];
         end
      end
   end

   always_comb begin
      priority if (restart) begin
         chip_in_symbol_in = '0;
      end else if (chip_accept) begin
         chip_in_symbol_in = (chip_in_symbol_ff >= sf_m1) ? '0
                                                          : chip_in_symbol_ff + AddrW'(1);
      end else begin
         chip_in_symbol_in = chip_in_symbol_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chip_in_symbol_ff <= '0;
      end else begin
         chip_in_symbol_ff <= chip_in_symbol_in;
      end
   end

   // pipeline control
   assign s2_ready   = ~rsp_valid_ff | rsp_tready;
   assign req_tready = ~s1_valid_ff | s2_ready;

   always_comb begin
      priority if (req_accept) begin
         s1_valid_in = chip_accept;
      end else if (s2_ready) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
      rsp_valid_in = s2_ready ? s1_valid_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (chip_accept) begin
         s1_sym_ff           <= req_sym;
         s1_last_ff          <= (chip_in_symbol_ff >= sf_m1);
         s1_ctrl_ff.active   <= active;
         s1_ctrl_ff.code_bit <= '0;
         s1_ctrl_ff.users_n  <= users_n;
         s1_ctrl_ff.scale_en <= scale_enable_ff;
      end
   end

   always_comb begin
      comb_ctrl          = s1_ctrl_ff;
      comb_ctrl.code_bit = code_bit_ff;
   end

   mds_combiner u_combiner (
      .ctrl    (comb_ctrl),
      .sym     (s1_sym_ff),
      .chip_re (chip_re),
      .chip_im (chip_im)
   );

   always_ff @(posedge clock) begin
      if (s2_ready && s1_valid_ff) begin
         rsp_re_ff   <= chip_re;
         rsp_im_ff   <= chip_im;
         rsp_last_ff <= s1_last_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = mds_pkg::RspDataW'({rsp_im_ff, rsp_re_ff});

   a_full_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && rsp_valid_ff && !rsp_tready) |-> !req_tready)
      else $error("input taken while both stages are stalled");

   a_load_restarts: assert property (@(posedge clock) disable iff (reset)
      load_accept |=> (chip_in_symbol_ff == '0 && code_phase_ff == '0))
      else $error("load item did not restart phases");

   a_symbol_count_bound: assert property (@(posedge clock) disable iff (reset)
      chip_in_symbol_ff <= sf_m1)
      else $error("chip counter beyond symbol length");

   a_rsp_from_stage1: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s1_valid_ff))
      else $error("result appeared without a pending item");

endmodule

FILE: tb/multiuser_dsss_spreader_test.sv
`timescale 1ns / 100ps

module multiuser_dsss_spreader_test;

   localparam int MaxUsers      = mds_pkg::MaxUsers;
   localparam int MaxCodeLen    = mds_pkg::MaxCodeLen;
   localparam int SymbolBits    = mds_pkg::SymbolBits;
   localparam int UserIdxW      = mds_pkg::UserIdxW;
   localparam int UsersW        = mds_pkg::UsersW;
   localparam int AddrW         = mds_pkg::AddrW;
   localparam int ChipW         = mds_pkg::ChipW;
   localparam int ScaleShift    = mds_pkg::ScaleShift;
   localparam int SpreadLog2W   = mds_pkg::SpreadLog2W;
   localparam int SpreadLog2Min = mds_pkg::SpreadLog2Min;
   localparam int SpreadLog2Max = mds_pkg::SpreadLog2Max;
   localparam int CsrIdxW       = mds_pkg::CsrIdxW;
   localparam int CsrDataW      = mds_pkg::CsrDataW;
   localparam int LoadAddrLsb   = mds_pkg::LoadAddrLsb;
   localparam int LoadChipBit   = mds_pkg::LoadChipBit;
   localparam int SymLsb        = mds_pkg::SymLsb;
   localparam int ReqDataW      = mds_pkg::ReqDataW;
   localparam int RspDataW      = mds_pkg::RspDataW;

   localparam int CycleLimit  = 500000;
   localparam int ItemsTarget = 1950;
   localparam int PipeDepth   = 2;
   localparam int HoldCycles  = 200;
   localparam int MaxPrinted  = 50;

   localparam logic [CsrIdxW-1:0] RegUnmapped = 3'd7;

   localparam mds_pkg::sym_type SymMin = {1'b1, {(SymbolBits-1){1'b0}}};
   localparam mds_pkg::sym_type SymMax = {1'b0, {(SymbolBits-1){1'b1}}};

   localparam int RootScale [0:MaxUsers] = '{32768, 32768, 23170, 18919, 16384};

   typedef struct packed {
      mds_pkg::op_type                        op;
      logic [UserIdxW-1:0]                    load_user;
      logic [AddrW-1:0]                       load_addr;
      logic                                   load_chip;
      mds_pkg::sym_type [MaxUsers-1:0]        re;
      mds_pkg::sym_type [MaxUsers-1:0]        im;
   } spread_item_type;

   typedef struct packed {
      mds_pkg::chip_type re;
      mds_pkg::chip_type im;
      logic              last;
   } chip_result_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [ReqDataW-1:0]    req_tdata = '0;
   logic                   req_tuser = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RspDataW-1:0]    rsp_tdata;
   logic                   rsp_tlast;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CsrIdxW-1:0]     csr_index = '0;
   logic [CsrDataW-1:0]    csr_data = '0;

   multiuser_dsss_spreader dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // spreader state as the testbench sees it
   bit  code_bits    [MaxUsers][MaxCodeLen];
   bit  code_written [MaxUsers][MaxCodeLen];
   int  user_phase   [MaxUsers];
   int  symbol_pos;
   int  cfg_spread = 5;
   int  cfg_users  = 4;
   bit  cfg_scale  = 1'b1;
   int  cfg_len    [MaxUsers] = '{32, 32, 32, 32};

   chip_result_type pending_chips [$];
   chip_result_type want_chip;

   int mismatch_count;
   int items_sent;
   int cycle_count;
   int burst_left;
   int gap_pct   = 30;
   int stall_pct = 20;
   int stall_left;
   int hold_count;
   int holds_done;
   int hold_left;

   function automatic int spread_eff();
      if (cfg_spread < SpreadLog2Min) return SpreadLog2Min;
      if (cfg_spread > SpreadLog2Max) return SpreadLog2Max;
      return cfg_spread;
   endfunction

   function automatic int active_count();
      if (cfg_users < 1) return 1;
      if (cfg_users > MaxUsers) return MaxUsers;
      return cfg_users;
   endfunction

   function automatic int code_len_eff(input int u);
      if (cfg_len[u] < 1) return 1;
      if (cfg_len[u] > MaxCodeLen) return MaxCodeLen;
      return cfg_len[u];
   endfunction

   function automatic void restart_phases();
      int u;
      for (u = 0; u < MaxUsers; u++) user_phase[u] = 0;
      symbol_pos = 0;
   endfunction

   function automatic void spread_predict(input spread_item_type it);
      int u, n;
      logic signed [63:0] acc_re, acc_im;
      chip_result_type chip;
      if (it.op == mds_pkg::OpLoad) begin
         code_bits[it.load_user][it.load_addr] = it.load_chip;
         code_written[it.load_user][it.load_addr] = 1'b1;
         restart_phases();
         return;
      end
      n = active_count();
      acc_re = '0;
      acc_im = '0;
      for (u = 0; u < n; u++) begin
         if (code_bits[u][user_phase[u]]) begin
            acc_re = acc_re + 64'($signed(it.re[u]));
            acc_im = acc_im + 64'($signed(it.im[u]));
         end else begin
            acc_re = acc_re - 64'($signed(it.re[u]));
            acc_im = acc_im - 64'($signed(it.im[u]));
         end
         user_phase[u] = (user_phase[u] + 1 >= code_len_eff(u)) ? 0 : user_phase[u] + 1;
      end
      if (cfg_scale) begin
         acc_re = (acc_re * 64'(RootScale[n])) >>> ScaleShift;
         acc_im = (acc_im * 64'(RootScale[n])) >>> ScaleShift;
      end
      chip.re = acc_re[ChipW-1:0];
      chip.im = acc_im[ChipW-1:0];
      chip.last = (symbol_pos >= (1 << spread_eff()) - 1);
      symbol_pos = chip.last ? 0 : symbol_pos + 1;
      pending_chips.push_back(chip);
   endfunction

   function automatic logic [ReqDataW-1:0] pack_item(input spread_item_type it);
      logic [ReqDataW-1:0] d;
      int u;
      d = '0;
      d[UserIdxW-1:0] = it.load_user;
      d[LoadAddrLsb +: AddrW] = it.load_addr;
      d[LoadChipBit] = it.load_chip;
      for (u = 0; u < MaxUsers; u++) begin
         d[SymLsb + 2*SymbolBits*u +: SymbolBits] = it.re[u];
         d[SymLsb + 2*SymbolBits*u + SymbolBits +: SymbolBits] = it.im[u];
      end
      return d;
   endfunction

   function automatic mds_pkg::sym_type rand_sym();
      int pick;
      pick = int'($urandom_range(0, 7));
      if (pick == 0) return SymMin;
      if (pick == 1) return SymMax;
      return SymbolBits'($urandom);
   endfunction

   function automatic spread_item_type chip_item_rand();
      spread_item_type it;
      int u;
      it.op = mds_pkg::OpChip;
      it.load_user = UserIdxW'($urandom);
      it.load_addr = AddrW'($urandom);
      it.load_chip = 1'($urandom);
      for (u = 0; u < MaxUsers; u++) begin
         it.re[u] = rand_sym();
         it.im[u] = rand_sym();
      end
      return it;
   endfunction

   function automatic spread_item_type chip_item_same(input mds_pkg::sym_type s);
      spread_item_type it;
      int u;
      it = chip_item_rand();
      for (u = 0; u < MaxUsers; u++) begin
         it.re[u] = s;
         it.im[u] = s;
      end
      return it;
   endfunction

   function automatic spread_item_type load_item(input int user, input int addr, input int chip);
      spread_item_type it;
      it = chip_item_rand();
      it.op = mds_pkg::OpLoad;
      it.load_user = UserIdxW'(user);
      it.load_addr = AddrW'(addr);
      it.load_chip = 1'(chip);
      return it;
   endfunction

   task automatic flag_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= MaxPrinted) $display("MISMATCH at %0t: %s", $time, msg);
   endtask

   task automatic send_item(input spread_item_type it);
      req_tvalid <= 1'b1;
      req_tdata <= pack_item(it);
      req_tuser <= it.op;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      spread_predict(it);
      items_sent++;
      if (burst_left == 0) begin
         burst_left = int'($urandom_range(1, 16));
         if (int'($urandom_range(0, 99)) < gap_pct) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
      end else begin
         burst_left--;
      end
   endtask

   // leaves csr_valid high; the caller drops it after its last write
   task automatic set_reg(input logic [CsrIdxW-1:0] idx, input int value);
      logic [CsrDataW-1:0] v;
      v = CsrDataW'(value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         mds_pkg::RegSpreadLog2: begin
            cfg_spread = int'(v[SpreadLog2W-1:0]);
            restart_phases();
         end
         mds_pkg::RegActiveUsers: cfg_users = int'(v[UsersW-1:0]);
         mds_pkg::RegScaleEnable: cfg_scale = v[0];
         mds_pkg::RegCodeLen0, mds_pkg::RegCodeLen1,
         mds_pkg::RegCodeLen2, mds_pkg::RegCodeLen3: begin
            cfg_len[int'(idx) - int'(mds_pkg::RegCodeLen0)] = int'(v);
            restart_phases();
         end
         default: ;
      endcase
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_chips.size() != 0);
   endtask

   task automatic settle();
      wait_drained();
      repeat (PipeDepth + 2) @(posedge clock);
   endtask

   task automatic load_missing_codes();
      int u, a;
      for (u = 0; u < active_count(); u++)
         for (a = 0; a < code_len_eff(u); a++)
            if (!code_written[u][a])
               send_item(load_item(u, a, int'($urandom_range(0, 1))));
   endtask

   task automatic test_code_load();
      int u;
      for (u = 0; u < MaxUsers; u++) send_item(load_item(u, 0, 1));
      for (u = 0; u < MaxUsers; u++) send_item(load_item(u, 1, 0));
      send_item(load_item(MaxUsers - 1, MaxCodeLen - 1, 1));
      send_item(load_item(MaxUsers - 1, MaxCodeLen - 1, 0));
      load_missing_codes();
   endtask

   task automatic test_symbol_extremes();
      int k;
      send_item(chip_item_same(SymMin));
      send_item(chip_item_same(SymMin));
      settle();
      set_reg(mds_pkg::RegScaleEnable, 0);
      set_reg(mds_pkg::RegCodeLen0, 32);
      csr_valid <= 1'b0;
      send_item(chip_item_same(SymMin));
      send_item(chip_item_same(SymMin));
      send_item(chip_item_same(SymMax));
      send_item(chip_item_same(SymMax));
      send_item(chip_item_same('0));
      for (k = 0; k < 4; k++) send_item(chip_item_rand());
   endtask

   task automatic test_config_corners();
      int k;
      settle();
      set_reg(mds_pkg::RegSpreadLog2, 0);
      set_reg(mds_pkg::RegActiveUsers, 0);
      set_reg(mds_pkg::RegScaleEnable, 1);
      csr_valid <= 1'b0;
      load_missing_codes();
      for (k = 0; k < 3; k++) send_item(chip_item_rand());
      settle();
      set_reg(mds_pkg::RegSpreadLog2, 15);
      set_reg(mds_pkg::RegActiveUsers, 7);
      set_reg(mds_pkg::RegCodeLen0, 0);
      set_reg(mds_pkg::RegCodeLen1, 1023);
      set_reg(mds_pkg::RegCodeLen2, 1);
      set_reg(mds_pkg::RegCodeLen3, 2);
      set_reg(RegUnmapped, int'($urandom_range(0, 1023)));
      csr_valid <= 1'b0;
      load_missing_codes();
      for (k = 0; k < 3; k++) send_item(chip_item_rand());
      send_item(load_item(2, 0, 1));
      for (k = 0; k < 3; k++) send_item(chip_item_rand());
   endtask

   task automatic test_backpressure();
      int k;
      settle();
      set_reg(mds_pkg::RegSpreadLog2, 5);
      set_reg(mds_pkg::RegActiveUsers, 4);
      set_reg(mds_pkg::RegCodeLen0, 32);
      set_reg(mds_pkg::RegCodeLen1, 32);
      set_reg(mds_pkg::RegCodeLen2, 32);
      set_reg(mds_pkg::RegCodeLen3, 32);
      csr_valid <= 1'b0;
      load_missing_codes();
      gap_pct = 0;
      hold_count++;
      for (k = 0; k < 40; k++) send_item(chip_item_rand());
      wait_drained();
      for (k = 0; k < 20; k++) send_item(chip_item_rand());
   endtask

   task automatic test_random_traffic();
      spread_item_type held;
      int k, u, n_chips, pick;
      bit loads_on;
      logic [CsrIdxW-1:0] len_idx;
      held = chip_item_rand();
      while (items_sent < ItemsTarget) begin
         settle();
         pick = int'($urandom_range(0, 2));
         gap_pct = (pick == 0) ? 0 : (pick == 1) ? 20 : 60;
         pick = int'($urandom_range(0, 2));
         stall_pct = (pick == 0) ? 0 : (pick == 1) ? 15 : 50;
         if ($urandom_range(0, 1) == 1) begin
            pick = int'($urandom_range(0, 19));
            if (pick < 12) set_reg(mds_pkg::RegSpreadLog2, 5);
            else if (pick < 16) set_reg(mds_pkg::RegSpreadLog2, 6);
            else if (pick == 19)
               set_reg(mds_pkg::RegSpreadLog2, int'($urandom_range(0, 15)));
            else set_reg(mds_pkg::RegSpreadLog2, pick - 9);
         end
         if ($urandom_range(0, 1) == 1) begin
            pick = int'($urandom_range(0, 9));
            if (pick == 0) set_reg(mds_pkg::RegActiveUsers, 0);
            else if (pick == 9)
               set_reg(mds_pkg::RegActiveUsers, int'($urandom_range(5, 7)));
            else set_reg(mds_pkg::RegActiveUsers, (pick - 1) % MaxUsers + 1);
         end
         if ($urandom_range(0, 1) == 1)
            set_reg(mds_pkg::RegScaleEnable, int'($urandom_range(0, 1)));
         for (u = 0; u < MaxUsers; u++) begin
            if ($urandom_range(0, 1) == 1) begin
               len_idx = CsrIdxW'(int'(mds_pkg::RegCodeLen0) + u);
               pick = int'($urandom_range(0, 19));
               if (pick == 0) set_reg(len_idx, 0);
               else if (pick == 1) set_reg(len_idx, MaxCodeLen);
               else if (pick == 2) set_reg(len_idx, int'($urandom_range(513, 1023)));
               else if (pick < 6) set_reg(len_idx, int'($urandom_range(1, 8)));
               else set_reg(len_idx, int'($urandom_range(1, 64)));
            end
         end
         csr_valid <= 1'b0;
         load_missing_codes();
         n_chips = int'($urandom_range(20, 120));
         if (spread_eff() >= 8) n_chips += 1 << spread_eff();
         loads_on = 1'($urandom_range(0, 1));
         for (k = 0; k < n_chips; k++) begin
            if (loads_on && $urandom_range(0, 31) == 0) begin
               send_item(load_item(int'($urandom_range(0, MaxUsers - 1)),
                                   int'($urandom_range(0, MaxCodeLen - 1)),
                                   int'($urandom_range(0, 1))));
            end else begin
               if ($urandom_range(0, 7) == 0) held = chip_item_rand();
               send_item(held);
            end
         end
      end
   endtask

   always @(posedge clock) begin
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (holds_done != hold_count) begin
         holds_done++;
         hold_left = HoldCycles;
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (int'($urandom_range(0, 99)) < stall_pct) begin
         stall_left = int'($urandom_range(0, 4));
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_chips.size() == 0) begin
            flag_mismatch("chip item with none expected");
         end else begin
            want_chip = pending_chips.pop_front();
            if (rsp_tdata[ChipW-1:0] !== want_chip.re)
               flag_mismatch($sformatf("chip_re got %0d want %0d",
                  $signed(rsp_tdata[ChipW-1:0]), want_chip.re));
            if (rsp_tdata[2*ChipW-1:ChipW] !== want_chip.im)
               flag_mismatch($sformatf("chip_im got %0d want %0d",
                  $signed(rsp_tdata[2*ChipW-1:ChipW]), want_chip.im));
            if (rsp_tlast !== want_chip.last)
               flag_mismatch($sformatf("symbol_end got %b want %b", rsp_tlast, want_chip.last));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin
      restart_phases();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_code_load();
      test_symbol_extremes();
      test_config_corners();
      test_backpressure();
      test_random_traffic();
      wait_drained();
      repeat (PipeDepth + 8) @(posedge clock);
      if (mismatch_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

FILE: sim.f
hdl/mds_pkg.sv
hdl/mds_combiner.sv
hdl/multiuser_dsss_spreader.sv
tb/multiuser_dsss_spreader_test.sv
